// ===== rtl/erm_pkg.sv =====
package erm_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int DELAY_LEN    = 4096;
    localparam int ADDR_W       = $clog2(DELAY_LEN);
    localparam int NUM_TAPS     = 3;
    localparam int TAP_IDX_W    = 2;
    localparam int TAP_DELAY_W  = 12;
    localparam int TAP_DELAYS_W = NUM_TAPS * TAP_DELAY_W;
    localparam int GAIN_W       = 16;
    localparam int GAIN_FRAC    = 12;
    localparam int PROD_W       = SAMPLE_BITS + GAIN_W + 1;
    localparam int SUM_W        = SAMPLE_BITS + 6;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int APB_DATA_W   = 64;
    localparam int REG_IDX_W    = 3;
    localparam int APB_ADDR_W   = REG_IDX_W + 3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [GAIN_W-1:0]             gain_t;
    typedef logic [ADDR_W-1:0]             addr_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] dry_sample;
        logic signed [SAMPLE_BITS-1:0] acc_left_in;
        logic signed [SAMPLE_BITS-1:0] acc_right_in;
        logic                          block_end;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] wet_left;
        logic signed [SAMPLE_BITS-1:0] wet_right;
        logic                          block_end_out;
        logic                          clipped;
    } out_item_t;

    // one tap transfer from the sequencer to the multiply-accumulate path
    typedef struct packed {
        logic                          valid;
        logic                          first;
        logic                          last;
        logic                          enable;
        logic [TAP_IDX_W-1:0]          tap;
        logic signed [SAMPLE_BITS-1:0] acc_left;
        logic signed [SAMPLE_BITS-1:0] acc_right;
        logic                          block_end;
    } tap_op_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_TAP0,
        SEQ_TAP1,
        SEQ_TAP2,
        SEQ_WRITE
    } seq_state_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_TAP_DELAYS,
        REG_TAP0_LEFT,
        REG_TAP0_RIGHT,
        REG_TAP1_LEFT,
        REG_TAP1_RIGHT,
        REG_TAP2_LEFT,
        REG_TAP2_RIGHT
    } cfg_reg_t;

endpackage

// ===== rtl/erm_delay_ram.sv =====
module erm_delay_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 24
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en && we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && !we) begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== rtl/erm_tap_seq.sv =====
module erm_tap_seq (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  erm_pkg::in_item_t                   s_data,
    input  logic                                credit_ok,
    input  logic [erm_pkg::TAP_DELAYS_W-1:0]    tap_delays,
    output erm_pkg::tap_op_t                    op,
    output erm_pkg::sample_t                    tap_sample
);

    erm_pkg::seq_state_t             state_reg;
    erm_pkg::seq_state_t             state_next;
    erm_pkg::in_item_t               item_reg;
    erm_pkg::addr_t                  wp_reg;
    erm_pkg::addr_t                  wp_next;
    logic                            wrapped_reg;
    logic                            wrapped_next;
    erm_pkg::tap_op_t                op_reg;
    erm_pkg::tap_op_t                op_next;

    logic                            accept;
    logic                            tap_active;
    logic [erm_pkg::TAP_DELAY_W-1:0] d_sel;
    logic [erm_pkg::TAP_IDX_W-1:0]   tap_sel;
    erm_pkg::addr_t                  d_clamp;
    erm_pkg::addr_t                  rd_addr;
    logic                            no_wrap;
    logic                            ram_en;
    logic                            ram_we;
    erm_pkg::addr_t                  ram_addr;
    logic [erm_pkg::SAMPLE_BITS-1:0] ram_rdata;

    assign s_ready = (state_reg == erm_pkg::SEQ_IDLE || state_reg == erm_pkg::SEQ_WRITE)
                     && credit_ok;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            erm_pkg::SEQ_IDLE:  state_next = accept ? erm_pkg::SEQ_TAP0 : erm_pkg::SEQ_IDLE;
            erm_pkg::SEQ_TAP0:  state_next = erm_pkg::SEQ_TAP1;
            erm_pkg::SEQ_TAP1:  state_next = erm_pkg::SEQ_TAP2;
            erm_pkg::SEQ_TAP2:  state_next = erm_pkg::SEQ_WRITE;
            erm_pkg::SEQ_WRITE: state_next = accept ? erm_pkg::SEQ_TAP0 : erm_pkg::SEQ_IDLE;
            default:            state_next = erm_pkg::SEQ_IDLE;
        endcase
    end

    always_comb begin
        d_sel      = '0;
        tap_sel    = '0;
        tap_active = 1'b0;
        ram_we     = 1'b0;
        unique case (state_reg)
            erm_pkg::SEQ_TAP0: begin
                d_sel      = tap_delays[erm_pkg::TAP_DELAY_W-1:0];
                tap_sel    = erm_pkg::TAP_IDX_W'(0);
                tap_active = 1'b1;
            end
            erm_pkg::SEQ_TAP1: begin
                d_sel      = tap_delays[2*erm_pkg::TAP_DELAY_W-1:erm_pkg::TAP_DELAY_W];
                tap_sel    = erm_pkg::TAP_IDX_W'(1);
                tap_active = 1'b1;
            end
            erm_pkg::SEQ_TAP2: begin
                d_sel      = tap_delays[3*erm_pkg::TAP_DELAY_W-1:2*erm_pkg::TAP_DELAY_W];
                tap_sel    = erm_pkg::TAP_IDX_W'(2);
                tap_active = 1'b1;
            end
            erm_pkg::SEQ_WRITE: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase

        // delays past the store length read the oldest entry
        if (32'(d_sel) > 32'(erm_pkg::DELAY_LEN - 1)) begin
            d_clamp = erm_pkg::ADDR_W'(erm_pkg::DELAY_LEN - 1);
        end else begin
            d_clamp = erm_pkg::ADDR_W'(d_sel);
        end
        no_wrap = wp_reg >= d_clamp;
        if (no_wrap) begin
            rd_addr = wp_reg - d_clamp;
        end else begin
            rd_addr = erm_pkg::ADDR_W'(32'(wp_reg) + erm_pkg::DELAY_LEN - 32'(d_clamp));
        end

        ram_en   = tap_active || ram_we;
        ram_addr = ram_we ? wp_reg : rd_addr;

        // entries not yet written since reset read as zero
        op_next           = '0;
        op_next.valid     = tap_active;
        op_next.first     = state_reg == erm_pkg::SEQ_TAP0;
        op_next.last      = state_reg == erm_pkg::SEQ_TAP2;
        op_next.enable    = (d_sel != '0) && (wrapped_reg || no_wrap);
        op_next.tap       = tap_sel;
        op_next.acc_left  = item_reg.acc_left_in;
        op_next.acc_right = item_reg.acc_right_in;
        op_next.block_end = item_reg.block_end;

        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        if (ram_we) begin
            if (wp_reg == erm_pkg::ADDR_W'(erm_pkg::DELAY_LEN - 1)) begin
                wp_next      = '0;
                wrapped_next = 1'b1;
            end else begin
                wp_next = wp_reg + erm_pkg::ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= erm_pkg::SEQ_IDLE;
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            op_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
            op_reg      <= op_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
    end

    erm_delay_ram #(
        .DEPTH (erm_pkg::DELAY_LEN),
        .WIDTH (erm_pkg::SAMPLE_BITS)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (item_reg.dry_sample),
        .rdata (ram_rdata)
    );

    assign op         = op_reg;
    assign tap_sample = erm_pkg::sample_t'(ram_rdata);

endmodule

// ===== rtl/erm_tap_mac.sv =====
module erm_tap_mac (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  erm_pkg::tap_op_t                     op,
    input  erm_pkg::sample_t                     tap_sample,
    input  erm_pkg::gain_t [erm_pkg::NUM_TAPS-1:0] gain_left,
    input  erm_pkg::gain_t [erm_pkg::NUM_TAPS-1:0] gain_right,
    output logic                                 push_valid,
    output erm_pkg::out_item_t                   push_data
);

    localparam logic signed [erm_pkg::PROD_W-1:0] ROUND_BIAS =
        erm_pkg::PROD_W'(2 ** (erm_pkg::GAIN_FRAC - 1));
    localparam logic signed [erm_pkg::SUM_W-1:0] SAT_MAX =
        erm_pkg::SUM_W'(2 ** (erm_pkg::SAMPLE_BITS - 1) - 1);
    localparam logic signed [erm_pkg::SUM_W-1:0] SAT_MIN =
        erm_pkg::SUM_W'(-(2 ** (erm_pkg::SAMPLE_BITS - 1)));

    erm_pkg::tap_op_t                    st_op_reg;
    logic signed [erm_pkg::PROD_W-1:0]   prod_l_reg;
    logic signed [erm_pkg::PROD_W-1:0]   prod_r_reg;
    logic signed [erm_pkg::SUM_W-1:0]    sum_l_reg;
    logic signed [erm_pkg::SUM_W-1:0]    sum_r_reg;

    erm_pkg::sample_t                    smp;
    logic signed [erm_pkg::GAIN_W:0]     gl;
    logic signed [erm_pkg::GAIN_W:0]     gr;
    logic signed [erm_pkg::PROD_W-1:0]   prod_l_next;
    logic signed [erm_pkg::PROD_W-1:0]   prod_r_next;
    logic signed [erm_pkg::PROD_W-1:0]   shl;
    logic signed [erm_pkg::PROD_W-1:0]   shr;
    logic signed [erm_pkg::SUM_W-1:0]    sum_l_next;
    logic signed [erm_pkg::SUM_W-1:0]    sum_r_next;
    logic signed [erm_pkg::SUM_W-1:0]    sat_l;
    logic signed [erm_pkg::SUM_W-1:0]    sat_r;
    logic                                hit_l;
    logic                                hit_r;

    // stage 1: tap sample times both gains
    always_comb begin
        smp = op.enable ? tap_sample : '0;
        case (op.tap)
            erm_pkg::TAP_IDX_W'(1): begin
                gl = signed'({1'b0, gain_left[1]});
                gr = signed'({1'b0, gain_right[1]});
            end
            erm_pkg::TAP_IDX_W'(2): begin
                gl = signed'({1'b0, gain_left[2]});
                gr = signed'({1'b0, gain_right[2]});
            end
            default: begin
                gl = signed'({1'b0, gain_left[0]});
                gr = signed'({1'b0, gain_right[0]});
            end
        endcase
        prod_l_next = smp * gl;
        prod_r_next = smp * gr;
    end

    // stage 2: round half up, accumulate, saturate on the last tap
    always_comb begin
        shl = (prod_l_reg + ROUND_BIAS) >>> erm_pkg::GAIN_FRAC;
        shr = (prod_r_reg + ROUND_BIAS) >>> erm_pkg::GAIN_FRAC;
        if (st_op_reg.first) begin
            sum_l_next = erm_pkg::SUM_W'(st_op_reg.acc_left) + erm_pkg::SUM_W'(shl);
            sum_r_next = erm_pkg::SUM_W'(st_op_reg.acc_right) + erm_pkg::SUM_W'(shr);
        end else begin
            sum_l_next = sum_l_reg + erm_pkg::SUM_W'(shl);
            sum_r_next = sum_r_reg + erm_pkg::SUM_W'(shr);
        end

        hit_l = 1'b0;
        sat_l = sum_l_next;
        if (sum_l_next > SAT_MAX) begin
            sat_l = SAT_MAX;
            hit_l = 1'b1;
        end else if (sum_l_next < SAT_MIN) begin
            sat_l = SAT_MIN;
            hit_l = 1'b1;
        end

        hit_r = 1'b0;
        sat_r = sum_r_next;
        if (sum_r_next > SAT_MAX) begin
            sat_r = SAT_MAX;
            hit_r = 1'b1;
        end else if (sum_r_next < SAT_MIN) begin
            sat_r = SAT_MIN;
            hit_r = 1'b1;
        end

        push_valid              = st_op_reg.valid && st_op_reg.last;
        push_data.wet_left      = sat_l[erm_pkg::SAMPLE_BITS-1:0];
        push_data.wet_right     = sat_r[erm_pkg::SAMPLE_BITS-1:0];
        push_data.block_end_out = st_op_reg.block_end;
        push_data.clipped       = hit_l || hit_r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_op_reg <= '0;
        end else begin
            st_op_reg <= op;
        end
    end

    always_ff @(posedge aclk) begin
        prod_l_reg <= prod_l_next;
        prod_r_reg <= prod_r_next;
        if (st_op_reg.valid) begin
            sum_l_reg <= sum_l_next;
            sum_r_reg <= sum_r_next;
        end
    end

endmodule

// ===== rtl/erm_out_fifo.sv =====
module erm_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    input  erm_pkg::out_item_t push_data,
    output logic               m_valid,
    input  logic               m_ready,
    output erm_pkg::out_item_t m_data
);

    erm_pkg::out_item_t                entry_reg [erm_pkg::FIFO_DEPTH];
    logic [erm_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [erm_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [erm_pkg::CREDIT_W-1:0]      count_reg;
    logic [erm_pkg::CREDIT_W-1:0]      count_next;
    logic                              pop;

    assign m_valid = count_reg != '0;
    assign m_data  = entry_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        count_next = count_reg;
        if (push_valid && !pop) begin
            count_next = count_reg + erm_pkg::CREDIT_W'(1);
        end else if (pop && !push_valid) begin
            count_next = count_reg - erm_pkg::CREDIT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + erm_pkg::FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + erm_pkg::FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/early_reflection_tap_mixer.sv =====
// Channel   Direction  Payload     Handshake
// s_        in         in_item_t   s_valid / s_ready
// m_        out        out_item_t  m_valid / m_ready
// APB       in/out     64-bit regs psel / penable / pwrite, pready tied high
//
// Each sample takes three tap reads and one write on the single delay
// memory port, one per state; the next sample is taken in the write state.
// Synchronous active-low reset; delay entries not yet written read as zero.
// Up to four samples may be outstanding; input stalls once the output queue
// could fill, so m_ready low stops intake after four results wait.
module early_reflection_tap_mixer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  erm_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output erm_pkg::out_item_t                m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [erm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [erm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [erm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [erm_pkg::TAP_DELAYS_W-1:0]         tap_delays_reg;
    erm_pkg::gain_t [erm_pkg::NUM_TAPS-1:0]   gain_left_reg;
    erm_pkg::gain_t [erm_pkg::NUM_TAPS-1:0]   gain_right_reg;
    logic [erm_pkg::CREDIT_W-1:0]             outstanding_reg;
    logic [erm_pkg::CREDIT_W-1:0]             outstanding_next;

    erm_pkg::cfg_reg_t                        reg_sel;
    logic                                     cfg_write;
    logic                                     credit_ok;
    logic                                     in_xfer;
    logic                                     out_xfer;
    erm_pkg::tap_op_t                         op;
    erm_pkg::sample_t                         tap_sample;
    logic                                     push_valid;
    erm_pkg::out_item_t                       push_data;

    assign pready    = 1'b1;
    assign reg_sel   = erm_pkg::cfg_reg_t'(paddr[erm_pkg::APB_ADDR_W-1:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_delays_reg <= '0;
            gain_left_reg  <= '0;
            gain_right_reg <= '0;
        end else if (cfg_write) begin
            unique case (reg_sel)
                erm_pkg::REG_TAP_DELAYS: tap_delays_reg <= pwdata[erm_pkg::TAP_DELAYS_W-1:0];
                erm_pkg::REG_TAP0_LEFT:  gain_left_reg[0]  <= pwdata[erm_pkg::GAIN_W-1:0];
                erm_pkg::REG_TAP0_RIGHT: gain_right_reg[0] <= pwdata[erm_pkg::GAIN_W-1:0];
                erm_pkg::REG_TAP1_LEFT:  gain_left_reg[1]  <= pwdata[erm_pkg::GAIN_W-1:0];
                erm_pkg::REG_TAP1_RIGHT: gain_right_reg[1] <= pwdata[erm_pkg::GAIN_W-1:0];
                erm_pkg::REG_TAP2_LEFT:  gain_left_reg[2]  <= pwdata[erm_pkg::GAIN_W-1:0];
                erm_pkg::REG_TAP2_RIGHT: gain_right_reg[2] <= pwdata[erm_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            erm_pkg::REG_TAP_DELAYS: prdata = erm_pkg::APB_DATA_W'(tap_delays_reg);
            erm_pkg::REG_TAP0_LEFT:  prdata = erm_pkg::APB_DATA_W'(gain_left_reg[0]);
            erm_pkg::REG_TAP0_RIGHT: prdata = erm_pkg::APB_DATA_W'(gain_right_reg[0]);
            erm_pkg::REG_TAP1_LEFT:  prdata = erm_pkg::APB_DATA_W'(gain_left_reg[1]);
            erm_pkg::REG_TAP1_RIGHT: prdata = erm_pkg::APB_DATA_W'(gain_right_reg[1]);
            erm_pkg::REG_TAP2_LEFT:  prdata = erm_pkg::APB_DATA_W'(gain_left_reg[2]);
            erm_pkg::REG_TAP2_RIGHT: prdata = erm_pkg::APB_DATA_W'(gain_right_reg[2]);
            default:                 prdata = '0;
        endcase
    end

    // samples in flight or queued never exceed the output queue depth
    assign credit_ok = outstanding_reg < erm_pkg::CREDIT_W'(erm_pkg::FIFO_DEPTH);
    assign in_xfer   = s_valid && s_ready;
    assign out_xfer  = m_valid && m_ready;

    always_comb begin
        outstanding_next = outstanding_reg;
        if (in_xfer && !out_xfer) begin
            outstanding_next = outstanding_reg + erm_pkg::CREDIT_W'(1);
        end else if (out_xfer && !in_xfer) begin
            outstanding_next = outstanding_reg - erm_pkg::CREDIT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_next;
        end
    end

    erm_tap_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .credit_ok  (credit_ok),
        .tap_delays (tap_delays_reg),
        .op         (op),
        .tap_sample (tap_sample)
    );

    erm_tap_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op),
        .tap_sample (tap_sample),
        .gain_left  (gain_left_reg),
        .gain_right (gain_right_reg),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    erm_out_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        outstanding_reg <= erm_pkg::CREDIT_W'(erm_pkg::FIFO_DEPTH))
        else $error("outstanding count above queue depth");

    a_out_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> outstanding_reg != '0)
        else $error("result without an outstanding sample");

    a_push_has_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> outstanding_reg != '0)
        else $error("queue push without an outstanding sample");

    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_ready)
        else $error("input ready while the memory port is busy");
`endif

endmodule
